@@ src/irrseq_pkg.sv @@
package irrseq_pkg;

   // watering machine states, as shown on rsp_sys_state
   typedef enum logic [3:0] {
      ST_IDLE   = 4'd0,
      ST_READY  = 4'd1,
      ST_ACTIVE = 4'd2,
      ST_MSTOP  = 4'd3,
      ST_MSTART = 4'd4,
      ST_DONE   = 4'd5,
      ST_ERROR  = 4'd6,
      ST_DELAY  = 4'd7,
      ST_SLEEP  = 4'd8
   } sys_state_type;

   // controller phases of one control pass
   typedef enum logic [3:0] {
      CS_WAIT,
      CS_TOGGLE,
      CS_DAY,
      CS_SCHED,
      CS_COND,
      CS_AUTO,
      CS_SUPER,
      CS_DIV_LOAD,
      CS_DIV_STEP,
      CS_RESULT
   } ctrl_state_type;

   // register indexes on the csr port (byte address is 4 times the index)
   localparam logic [2:0] REG_MOISTURE_TARGET = 3'd0;
   localparam logic [2:0] REG_TANK_TEMP_MIN   = 3'd1;
   localparam logic [2:0] REG_WATER_DURATION  = 3'd2;
   localparam logic [2:0] REG_START_HOUR      = 3'd3;
   localparam logic [2:0] REG_STOP_ERROR_MASK = 3'd4;

   localparam int          CSR_ADDR_W   = 5;
   localparam logic [6:0]  PCT_FULL     = 7'd100;
   localparam logic [6:0]  PCT_ZERO     = 7'd0;
   localparam logic [4:0]  HOUR_NONE    = 5'd31;
   localparam logic [2:0]  DIV_LAST_BIT = 3'd6;

   typedef struct packed {
      logic        [6:0]  moisture_target;
      logic signed [11:0] tank_temp_min;
      logic        [26:0] water_duration_ms;
      logic        [4:0]  start_hour;
      logic        [7:0]  stop_error_mask;
   } cfg_type;

   typedef struct packed {
      logic          load;
      logic          go_en;
      sys_state_type go_tgt;
      logic          day_clear;
      logic          set_prev;
      logic          set_due;
      logic          eval_ready;
      logic          pend_total;
      logic          div_load;
      logic          div_step;
      logic          out_load;
   } cmd_type;

   typedef struct packed {
      sys_state_type cur;
      logic          mode;
      logic          stopping;
      logic          hour_new;
      logic          hour_zero;
      logic          ready_hour;
      logic          start_hit;
      logic          done;
      logic          due;
      logic          ready;
      logic          finish;
      logic          pend;
      logic          pend_ge;
      logic          div_last;
   } status_type;

   function automatic logic is_watering(sys_state_type s);
      return (s == ST_ACTIVE) || (s == ST_MSTART);
   endfunction

endpackage

@@ src/irrseq_ctrl.sv @@
module irrseq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  irrseq_pkg::status_type  status,
   output irrseq_pkg::cmd_type     cmd
);

   irrseq_pkg::ctrl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != irrseq_pkg::CS_WAIT);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= irrseq_pkg::CS_WAIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         irrseq_pkg::CS_WAIT: begin
            if (req_valid) state_in = irrseq_pkg::CS_TOGGLE;
         end
         irrseq_pkg::CS_TOGGLE:   state_in = irrseq_pkg::CS_DAY;
         irrseq_pkg::CS_DAY:      state_in = irrseq_pkg::CS_SCHED;
         irrseq_pkg::CS_SCHED:    state_in = irrseq_pkg::CS_COND;
         irrseq_pkg::CS_COND:     state_in = irrseq_pkg::CS_AUTO;
         irrseq_pkg::CS_AUTO:     state_in = irrseq_pkg::CS_SUPER;
         irrseq_pkg::CS_SUPER:    state_in = irrseq_pkg::CS_DIV_LOAD;
         irrseq_pkg::CS_DIV_LOAD: begin
            if (!status.pend || status.pend_ge) state_in = irrseq_pkg::CS_RESULT;
            else state_in = irrseq_pkg::CS_DIV_STEP;
         end
         irrseq_pkg::CS_DIV_STEP: begin
            if (status.div_last) state_in = irrseq_pkg::CS_RESULT;
         end
         irrseq_pkg::CS_RESULT: begin
            if (out_free) state_in = irrseq_pkg::CS_WAIT;
         end
         default: state_in = irrseq_pkg::CS_WAIT;
      endcase
   end

   // commands to the datapath
   always_comb begin
      cmd = '0;
      cmd.go_tgt = irrseq_pkg::ST_IDLE;
      case (state_ff)
         irrseq_pkg::CS_WAIT: begin
            cmd.load = req_valid;
         end
         irrseq_pkg::CS_TOGGLE: begin
            if (status.mode) begin
               cmd.go_en = 1'b1;
               if (irrseq_pkg::is_watering(status.cur)) cmd.go_tgt = irrseq_pkg::ST_MSTOP;
               else if (status.stopping) cmd.go_tgt = irrseq_pkg::ST_ERROR;
               else cmd.go_tgt = irrseq_pkg::ST_MSTART;
            end
         end
         irrseq_pkg::CS_DAY: begin
            if (status.hour_new) begin
               cmd.set_prev = 1'b1;
               if (status.hour_zero) begin
                  cmd.go_en     = 1'b1;
                  cmd.go_tgt    = irrseq_pkg::ST_IDLE;
                  cmd.day_clear = 1'b1;
               end
            end
         end
         irrseq_pkg::CS_SCHED: begin
            if (!status.done && status.cur != irrseq_pkg::ST_MSTART) begin
               if (status.ready_hour && status.cur == irrseq_pkg::ST_IDLE) begin
                  cmd.go_en  = 1'b1;
                  cmd.go_tgt = irrseq_pkg::ST_READY;
               end else if (status.start_hit) begin
                  cmd.set_due = 1'b1;
               end
            end
         end
         irrseq_pkg::CS_COND: begin
            if (status.stopping) begin
               cmd.go_en  = 1'b1;
               cmd.go_tgt = irrseq_pkg::ST_ERROR;
            end else begin
               cmd.go_en      = (status.cur == irrseq_pkg::ST_ERROR);
               cmd.go_tgt     = irrseq_pkg::ST_IDLE;
               cmd.eval_ready = 1'b1;
            end
         end
         irrseq_pkg::CS_AUTO: begin
            if (!(status.cur == irrseq_pkg::ST_MSTART || status.cur == irrseq_pkg::ST_MSTOP ||
                  status.cur == irrseq_pkg::ST_ACTIVE || status.cur == irrseq_pkg::ST_ERROR)) begin
               if (status.due && status.ready) begin
                  cmd.go_en  = 1'b1;
                  cmd.go_tgt = irrseq_pkg::ST_ACTIVE;
               end else if (status.due) begin
                  cmd.go_en  = 1'b1;
                  cmd.go_tgt = irrseq_pkg::ST_DELAY;
               end else if (status.cur == irrseq_pkg::ST_DELAY && status.ready) begin
                  cmd.go_en  = 1'b1;
                  cmd.go_tgt = irrseq_pkg::ST_READY;
               end
            end
         end
         irrseq_pkg::CS_SUPER: begin
            if (irrseq_pkg::is_watering(status.cur)) begin
               if (status.finish) begin
                  cmd.go_en  = 1'b1;
                  cmd.go_tgt = irrseq_pkg::ST_DONE;
               end else begin
                  cmd.pend_total = 1'b1;
               end
            end
         end
         irrseq_pkg::CS_DIV_LOAD: cmd.div_load = 1'b1;
         irrseq_pkg::CS_DIV_STEP: cmd.div_step = 1'b1;
         irrseq_pkg::CS_RESULT:   cmd.out_load = out_free;
         default: cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

endmodule

@@ src/irrseq_datapath.sv @@
module irrseq_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  irrseq_pkg::cfg_type     cfg,
   input  irrseq_pkg::cmd_type     cmd,
   output irrseq_pkg::status_type  status,
   input  logic                    req_mode,
   input  logic [31:0]             req_now_ms,
   input  logic [4:0]              req_hour,
   input  logic                    req_tank_full,
   input  logic signed [11:0]      req_tank_temp,
   input  logic [6:0]              req_moisture_a,
   input  logic [6:0]              req_moisture_b,
   input  logic [7:0]              req_error_flags,
   output logic [3:0]              rsp_sys_state,
   output logic                    rsp_pump_on,
   output logic [6:0]              rsp_progress,
   output logic                    rsp_due_now,
   output logic                    rsp_ready_ok,
   output logic                    rsp_done_today
);

   // captured pass inputs
   logic               mode_ff;
   logic [31:0]        now_ff;
   logic [4:0]         hour_ff;
   logic               tank_ff;
   logic signed [11:0] temp_ff;
   logic [6:0]         ma_ff, mb_ff;
   logic [7:0]         flags_ff;

   irrseq_pkg::sys_state_type cur_ff, cur_in;
   logic [31:0] session_ff, session_in;
   logic [31:0] watered_ff, watered_in;
   logic [6:0]  pct_ff, pct_in;
   logic        done_ff, done_in;
   logic        due_ff, due_in;
   logic        ready_ff, ready_in;
   logic [4:0]  prev_hour_ff, prev_hour_in;
   logic        pend_ff, pend_in;
   logic [31:0] pend_val_ff, pend_val_in;
   logic [33:0] rem_ff, rem_in;
   logic [6:0]  quo_ff, quo_in;
   logic [2:0]  cnt_ff, cnt_in;

   logic [31:0] acc_total;
   logic [31:0] dur_ext;
   logic [33:0] div_shifted;
   logic        div_take;
   logic [6:0]  quo_next;
   logic        go_chg;

   assign dur_ext     = {5'b0, cfg.water_duration_ms};
   assign acc_total   = watered_ff + (now_ff - session_ff);
   assign go_chg      = cmd.go_en && (cmd.go_tgt != cur_ff);
   assign div_shifted = {7'b0, cfg.water_duration_ms} << cnt_ff;
   assign div_take    = (rem_ff >= div_shifted);
   assign quo_next    = {quo_ff[5:0], div_take};

   always_comb begin
      status.cur        = cur_ff;
      status.mode       = mode_ff;
      status.stopping   = |(flags_ff & cfg.stop_error_mask);
      status.hour_new   = (hour_ff != prev_hour_ff);
      status.hour_zero  = (hour_ff == 5'd0);
      status.ready_hour = (cfg.start_hour != 5'd0) && (hour_ff == cfg.start_hour - 5'd1);
      status.start_hit  = (hour_ff == cfg.start_hour);
      status.done       = done_ff;
      status.due        = due_ff;
      status.ready      = ready_ff;
      status.finish     = (acc_total >= dur_ext) ||
                          (ma_ff >= cfg.moisture_target && mb_ff >= cfg.moisture_target &&
                           cur_ff == irrseq_pkg::ST_ACTIVE);
      status.pend       = pend_ff;
      status.pend_ge    = (pend_val_ff >= dur_ext);
      status.div_last   = (cnt_ff == 3'd0);
   end

   // progress is kept as a pending dividend until the end of the pass,
   // the last write in the pass decides it
   always_comb begin
      cur_in       = cur_ff;
      session_in   = session_ff;
      watered_in   = watered_ff;
      pct_in       = pct_ff;
      done_in      = done_ff;
      due_in       = due_ff;
      ready_in     = ready_ff;
      prev_hour_in = prev_hour_ff;
      pend_in      = pend_ff;
      pend_val_in  = pend_val_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;

      if (go_chg) begin
         if (irrseq_pkg::is_watering(cur_ff)) begin
            watered_in  = acc_total;
            pend_in     = 1'b1;
            pend_val_in = acc_total;
         end
         if (irrseq_pkg::is_watering(cmd.go_tgt)) session_in = now_ff;
         if (cmd.go_tgt == irrseq_pkg::ST_DONE) begin
            pct_in  = irrseq_pkg::PCT_FULL;
            pend_in = 1'b0;
            done_in = 1'b1;
            due_in  = 1'b0;
         end
         if (cmd.go_tgt == irrseq_pkg::ST_IDLE) begin
            watered_in = 32'd0;
            pct_in     = irrseq_pkg::PCT_ZERO;
            pend_in    = 1'b0;
         end
         cur_in = cmd.go_tgt;
      end

      if (cmd.day_clear) begin
         watered_in = 32'd0;
         pct_in     = irrseq_pkg::PCT_ZERO;
         pend_in    = 1'b0;
         due_in     = 1'b0;
         done_in    = 1'b0;
      end

      if (cmd.set_prev) prev_hour_in = hour_ff;
      if (cmd.set_due)  due_in = 1'b1;

      if (cmd.eval_ready) begin
         ready_in = tank_ff && ($signed(temp_ff) >= $signed(cfg.tank_temp_min)) &&
                    !done_ff && (cur_ff != irrseq_pkg::ST_MSTOP);
      end

      if (cmd.pend_total) begin
         pend_in     = 1'b1;
         pend_val_in = acc_total;
      end

      // at or past the budget the percentage saturates, else quotient fits 7 bits
      if (cmd.div_load && pend_ff) begin
         if (status.pend_ge) begin
            pct_in  = irrseq_pkg::PCT_FULL;
            pend_in = 1'b0;
         end else begin
            rem_in = {7'b0, pend_val_ff[26:0]} * 34'd100;
            quo_in = 7'd0;
            cnt_in = irrseq_pkg::DIV_LAST_BIT;
         end
      end

      if (cmd.div_step) begin
         rem_in = div_take ? (rem_ff - div_shifted) : rem_ff;
         quo_in = quo_next;
         cnt_in = cnt_ff - 3'd1;
         if (cnt_ff == 3'd0) begin
            pct_in  = quo_next;
            pend_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= irrseq_pkg::ST_IDLE;
         session_ff   <= 32'd0;
         watered_ff   <= 32'd0;
         pct_ff       <= irrseq_pkg::PCT_ZERO;
         done_ff      <= 1'b0;
         due_ff       <= 1'b0;
         ready_ff     <= 1'b0;
         prev_hour_ff <= irrseq_pkg::HOUR_NONE;
         pend_ff      <= 1'b0;
      end else begin
         cur_ff       <= cur_in;
         session_ff   <= session_in;
         watered_ff   <= watered_in;
         pct_ff       <= pct_in;
         done_ff      <= done_in;
         due_ff       <= due_in;
         ready_ff     <= ready_in;
         prev_hour_ff <= prev_hour_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_val_ff <= pend_val_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      if (cmd.load) begin
         mode_ff  <= req_mode;
         now_ff   <= req_now_ms;
         hour_ff  <= req_hour;
         tank_ff  <= req_tank_full;
         temp_ff  <= req_tank_temp;
         ma_ff    <= req_moisture_a;
         mb_ff    <= req_moisture_b;
         flags_ff <= req_error_flags;
      end
      if (cmd.out_load) begin
         rsp_sys_state  <= cur_ff;
         rsp_pump_on    <= irrseq_pkg::is_watering(cur_ff);
         rsp_progress   <= pct_ff;
         rsp_due_now    <= due_ff;
         rsp_ready_ok   <= ready_ff;
         rsp_done_today <= done_ff;
      end
   end

endmodule

@@ src/irrigation_sequencer_unit.sv @@
// channel | direction | handshake                | payload
// req     | in        | req_valid / req_stall    | one control pass
// rsp     | out       | rsp_valid / rsp_stall    | machine state, pump, progress, flags
// csr     | in/out    | csr_psel / csr_penable   | five setting registers, always ready
//
// a pass adds divider steps only when progress must be divided; the phases run one
// per cycle in the controller, the result phase waiting for a free output register;
// the progress percentage comes from a bit-serial divider, one quotient bit per cycle
// reset clears the machine to idle, the day flags, and the registers to their defaults
// the next pass is taken while a finished result still waits on rsp_stall, and a
// pass completes into the output register once that register is free

module irrigation_sequencer_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_mode,
   input  logic [31:0]                        req_now_ms,
   input  logic [4:0]                         req_hour,
   input  logic                               req_tank_full,
   input  logic signed [11:0]                 req_tank_temp,
   input  logic [6:0]                         req_moisture_a,
   input  logic [6:0]                         req_moisture_b,
   input  logic [7:0]                         req_error_flags,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [3:0]                         rsp_sys_state,
   output logic                               rsp_pump_on,
   output logic [6:0]                         rsp_progress,
   output logic                               rsp_due_now,
   output logic                               rsp_ready_ok,
   output logic                               rsp_done_today,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [irrseq_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   irrseq_pkg::cfg_type    cfg_ff;
   irrseq_pkg::cmd_type    cmd;
   irrseq_pkg::status_type status;
   logic                   csr_wr;
   logic [2:0]             csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.moisture_target   <= 7'd50;
         cfg_ff.tank_temp_min     <= 12'sd320;
         cfg_ff.water_duration_ms <= 27'd60000;
         cfg_ff.start_hour        <= 5'd13;
         cfg_ff.stop_error_mask   <= 8'd15;
      end else if (csr_wr) begin
         case (csr_idx)
            irrseq_pkg::REG_MOISTURE_TARGET: cfg_ff.moisture_target   <= csr_pwdata[6:0];
            irrseq_pkg::REG_TANK_TEMP_MIN:   cfg_ff.tank_temp_min     <= csr_pwdata[11:0];
            irrseq_pkg::REG_WATER_DURATION:  cfg_ff.water_duration_ms <= csr_pwdata[26:0];
            irrseq_pkg::REG_START_HOUR:      cfg_ff.start_hour        <= csr_pwdata[4:0];
            irrseq_pkg::REG_STOP_ERROR_MASK: cfg_ff.stop_error_mask   <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         irrseq_pkg::REG_MOISTURE_TARGET: csr_prdata = {25'd0, cfg_ff.moisture_target};
         irrseq_pkg::REG_TANK_TEMP_MIN:   csr_prdata = {20'd0, cfg_ff.tank_temp_min};
         irrseq_pkg::REG_WATER_DURATION:  csr_prdata = {5'd0, cfg_ff.water_duration_ms};
         irrseq_pkg::REG_START_HOUR:      csr_prdata = {27'd0, cfg_ff.start_hour};
         irrseq_pkg::REG_STOP_ERROR_MASK: csr_prdata = {24'd0, cfg_ff.stop_error_mask};
         default:                         csr_prdata = 32'd0;
      endcase
   end

   irrseq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   irrseq_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .cmd             (cmd),
      .status          (status),
      .req_mode        (req_mode),
      .req_now_ms      (req_now_ms),
      .req_hour        (req_hour),
      .req_tank_full   (req_tank_full),
      .req_tank_temp   (req_tank_temp),
      .req_moisture_a  (req_moisture_a),
      .req_moisture_b  (req_moisture_b),
      .req_error_flags (req_error_flags),
      .rsp_sys_state   (rsp_sys_state),
      .rsp_pump_on     (rsp_pump_on),
      .rsp_progress    (rsp_progress),
      .rsp_due_now     (rsp_due_now),
      .rsp_ready_ok    (rsp_ready_ok),
      .rsp_done_today  (rsp_done_today)
   );

endmodule

@@ src/irrseq_checker.sv @@
module irrseq_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [3:0] rsp_sys_state,
   input logic       rsp_pump_on,
   input logic [6:0] rsp_progress,
   input logic       rsp_due_now,
   input logic       rsp_done_today
);

   // the pump runs exactly in the two watering states
   a_pump_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pump_on == ((rsp_sys_state == irrseq_pkg::ST_ACTIVE) ||
                                     (rsp_sys_state == irrseq_pkg::ST_MSTART))))
      else $error("pump drive disagrees with machine state");

   // a finished day is never due again until midnight
   a_done_not_due: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_today) |-> !rsp_due_now)
      else $error("due flag set after watering completed");

   // the done state always reports a full budget and the day flag
   a_done_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_sys_state == irrseq_pkg::ST_DONE) |->
         (rsp_progress == irrseq_pkg::PCT_FULL && rsp_done_today))
      else $error("done state without full progress");

   a_progress_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_progress <= irrseq_pkg::PCT_FULL))
      else $error("progress above full scale");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_sys_state) &&
                                    $stable(rsp_progress)))
      else $error("stalled result changed");

endmodule

bind irrigation_sequencer_unit irrseq_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_sys_state  (rsp_sys_state),
   .rsp_pump_on    (rsp_pump_on),
   .rsp_progress   (rsp_progress),
   .rsp_due_now    (rsp_due_now),
   .rsp_done_today (rsp_done_today)
);
